/* rtl/event_cluster_tracker_core_defines.svh */
// Assertion macros used by the port-level checker file.
`ifndef EVENT_CLUSTER_TRACKER_CORE_DEFINES_SVH
`define EVENT_CLUSTER_TRACKER_CORE_DEFINES_SVH
// Implication checked at every rising clock edge outside reset.
`define ECT_ASSERT_IMP(label, clk, rst_n, a, c) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
    else $error("assertion failed");
// Next-cycle implication checked outside reset.
`define ECT_ASSERT_NXT(label, clk, rst_n, a, c) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
    else $error("assertion failed");
`endif

/* rtl/ect_pkg.sv */
// Package with types, constants and helper functions for the event cluster tracker.
package ect_pkg;
  localparam int TRACKER_COUNT = 8;
  localparam int TIME_MIX_SHIFT = 3;
  localparam int NO_MATCH_DIST = 262143;
  localparam int IDX_W = (TRACKER_COUNT > 1) ? $clog2(TRACKER_COUNT) : 1;
  localparam logic [3:0] CFG_MATCH = 4'd0;
  localparam logic [3:0] CFG_CAPTURE = 4'd1;
  localparam logic [3:0] CFG_RATE = 4'd2;
  localparam logic [3:0] CFG_CRATE = 4'd3;
  localparam logic [3:0] CFG_IMAX = 4'd4;
  localparam logic [3:0] CFG_PERIOD = 4'd5;
  localparam logic [3:0] CFG_PSHIFT = 4'd6;
  localparam logic [3:0] CFG_CSHIFT = 4'd7;

  typedef struct packed {
    logic        kind;
    logic [8:0]  event_x;
    logic [7:0]  event_y;
    logic [39:0] timestamp;
  } in_item_t;

  typedef struct packed {
    logic       result_kind;
    logic       matched;
    logic [5:0] tracker_index;
    logic       tracker_active;
    logic [8:0] pos_x;
    logic [7:0] pos_y;
    logic       last;
  } out_item_t;

  typedef struct packed {
    logic [17:0] match_dist_sq;
    logic [17:0] capture_dist_sq;
    logic [31:0] rate_threshold;
    logic [31:0] capture_rate_threshold;
    logic [31:0] interval_max;
    logic [31:0] cleanup_period;
    logic [3:0]  pos_mix_shift;
    logic [3:0]  capture_mix_shift;
  } cfg_t;

  typedef struct packed {
    logic load;
    logic scan;
    logic update;
    logic clean;
    logic clean_done;
    logic report;
  } ctl_t;

  typedef struct packed {
    logic is_eop;
    logic hit;
    logic do_clean;
  } sts_t;

  function automatic logic [33:0] mix_toward(input logic [33:0] v, input logic [33:0] t,
                                            input logic [3:0] k);
    logic signed [34:0] d;
    logic signed [34:0] s;
    begin
      d = $signed({1'b0, t}) - $signed({1'b0, v});
      s = d >>> k;
      mix_toward = 34'(v + s[33:0]);
    end
  endfunction

  function automatic logic [31:0] sample(input logic [39:0] now, input logic [39:0] then_t);
    logic [39:0] d;
    begin
      d = now - then_t;
      sample = (d[39:32] != 8'd0) ? 32'hFFFF_FFFF : d[31:0];
    end
  endfunction
endpackage

/* rtl/ect_ctrl.sv */
// Controller state machine sequencing scan, update, cleanup and reporting.
module ect_ctrl (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_valid,
  output logic         in_ready,
  input  logic         out_ready,
  output logic         out_valid,
  input  ect_pkg::sts_t sts,
  output ect_pkg::ctl_t ctl,
  output logic [ect_pkg::IDX_W-1:0] idx
);
  import ect_pkg::*;
  typedef enum logic [2:0] {S_IDLE, S_SCAN, S_UPD, S_CLEAN, S_REP, S_OUT} state_t;
  state_t state_r;
  logic [IDX_W-1:0] idx_r;
  logic out_valid_r;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TRACKER_COUNT - 1);

  assign in_ready = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign idx = (state_r == S_OUT) ? idx_r + 1'b1 : idx_r;

  always_comb begin
    ctl = '0;
    ctl.load = in_valid && in_ready;
    ctl.scan = (state_r == S_SCAN);
    ctl.update = (state_r == S_UPD);
    ctl.clean = (state_r == S_CLEAN);
    ctl.clean_done = (state_r == S_CLEAN) && (idx_r == LAST_IDX);
    ctl.report = (state_r == S_REP) ||
                 (state_r == S_OUT && out_ready && sts.is_eop && idx_r != LAST_IDX);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      idx_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      unique case (state_r)
        S_IDLE: if (in_valid) begin
          idx_r <= '0;
          state_r <= S_SCAN;
        end
        S_SCAN: begin
          if (sts.is_eop) begin
            idx_r <= '0;
            state_r <= sts.do_clean ? S_CLEAN : S_REP;
          end else if (idx_r == LAST_IDX) begin
            state_r <= S_UPD;
          end else begin
            idx_r <= idx_r + 1'b1;
          end
        end
        S_UPD: begin
          if (sts.hit) begin
            out_valid_r <= 1'b1;
            state_r <= S_OUT;
          end else begin
            state_r <= S_IDLE;
          end
        end
        S_CLEAN: begin
          if (idx_r == LAST_IDX) begin
            idx_r <= '0;
            state_r <= S_REP;
          end else begin
            idx_r <= idx_r + 1'b1;
          end
        end
        S_REP: begin
          out_valid_r <= 1'b1;
          state_r <= S_OUT;
        end
        S_OUT: if (out_ready) begin
          if (sts.is_eop && idx_r != LAST_IDX) begin
            idx_r <= idx_r + 1'b1;
          end else begin
            out_valid_r <= 1'b0;
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end
endmodule

/* rtl/ect_datapath.sv */
// Datapath holding the tracker table, the nearest-tracker search and the output register.
module ect_datapath (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      cfg_we,
  input  logic [3:0]                cfg_index,
  input  logic [31:0]               cfg_data,
  input  ect_pkg::in_item_t         in_data,
  input  ect_pkg::ctl_t             ctl,
  input  logic [ect_pkg::IDX_W-1:0] idx,
  output ect_pkg::sts_t             sts,
  output ect_pkg::out_item_t        out_data
);
  import ect_pkg::*;
  cfg_t cfg_r;
  in_item_t item_r;
  logic [15:0] tx_r [TRACKER_COUNT];
  logic [14:0] ty_r [TRACKER_COUNT];
  logic [31:0] mi_r [TRACKER_COUNT];
  logic [39:0] lt_r [TRACKER_COUNT];
  logic [TRACKER_COUNT-1:0] act_r;
  logic [39:0] lct_r;
  logic a_ok_r, n_ok_r;
  logic [17:0] a_best_r, n_best_r;
  logic [IDX_W-1:0] a_idx_r, n_idx_r;
  out_item_t out_r;

  logic signed [9:0] dx;
  logic signed [8:0] dy;
  logic [18:0] dsq;
  logic [39:0] tdiff;
  logic use_a, use_n;
  logic [IDX_W-1:0] u;
  logic [3:0] pk;
  logic [33:0] nx, ny, nm, cm;
  logic [31:0] nm32, cm32;

  assign dx = $signed({1'b0, item_r.event_x}) - $signed({1'b0, tx_r[idx][15:7]});
  assign dy = $signed({1'b0, item_r.event_y}) - $signed({1'b0, ty_r[idx][14:7]});
  assign dsq = 19'(dx * dx) + 19'(dy * dy);
  assign tdiff = item_r.timestamp - lct_r;
  assign use_a = a_ok_r && (a_best_r < cfg_r.match_dist_sq);
  assign use_n = !use_a && n_ok_r && (n_best_r < cfg_r.capture_dist_sq);
  assign u = use_a ? a_idx_r : n_idx_r;
  assign pk = use_a ? cfg_r.pos_mix_shift : cfg_r.capture_mix_shift;
  assign nx = mix_toward(34'(tx_r[u]), 34'({item_r.event_x, 7'd0}), pk);
  assign ny = mix_toward(34'(ty_r[u]), 34'({item_r.event_y, 7'd0}), pk);
  assign nm = mix_toward(34'(mi_r[u]), 34'(sample(item_r.timestamp, lt_r[u])),
                         4'(TIME_MIX_SHIFT));
  assign nm32 = (use_a || n_best_r < cfg_r.match_dist_sq) ? nm[31:0] : mi_r[u];
  assign cm = mix_toward(34'(mi_r[idx]), 34'(sample(item_r.timestamp, lt_r[idx])),
                         cfg_r.pos_mix_shift);
  assign cm32 = (cm[31:0] > cfg_r.interval_max) ? cfg_r.interval_max : cm[31:0];

  assign sts.is_eop = item_r.kind;
  assign sts.hit = use_a || use_n;
  assign sts.do_clean = (tdiff > 40'(cfg_r.cleanup_period));
  assign out_data = out_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '{18'd225, 18'd900, 32'd1000, 32'd2000, 32'd100000, 32'd1000, 4'd4, 4'd2};
      for (int i = 0; i < TRACKER_COUNT; i++) begin
        tx_r[i] <= {9'(((2 * i + 1) * 256) / TRACKER_COUNT), 7'd0};
        ty_r[i] <= {8'(((2 * i + 1) * 128) / TRACKER_COUNT), 7'd0};
        mi_r[i] <= 32'd100000;
        lt_r[i] <= '0;
      end
      act_r <= '0;
      lct_r <= '0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_MATCH:   cfg_r.match_dist_sq <= cfg_data[17:0];
          CFG_CAPTURE: cfg_r.capture_dist_sq <= cfg_data[17:0];
          CFG_RATE:    cfg_r.rate_threshold <= cfg_data;
          CFG_CRATE:   cfg_r.capture_rate_threshold <= cfg_data;
          CFG_IMAX:    cfg_r.interval_max <= cfg_data;
          CFG_PERIOD:  cfg_r.cleanup_period <= cfg_data;
          CFG_PSHIFT:  cfg_r.pos_mix_shift <= cfg_data[3:0];
          CFG_CSHIFT:  cfg_r.capture_mix_shift <= cfg_data[3:0];
          default: ;
        endcase
      end
      if (ctl.clean_done) begin
        lct_r <= item_r.timestamp;
      end
      if (ctl.update && (use_a || use_n)) begin
        tx_r[u] <= nx[15:0];
        ty_r[u] <= ny[14:0];
        mi_r[u] <= nm32;
        lt_r[u] <= item_r.timestamp;
        act_r[u] <= use_a ? (nm32 < cfg_r.rate_threshold)
                          : (nm32 < cfg_r.capture_rate_threshold);
      end
      if (ctl.clean) begin
        mi_r[idx] <= cm32;
        if (cm32 > cfg_r.rate_threshold) act_r[idx] <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      item_r <= in_data;
      a_ok_r <= 1'b0;
      n_ok_r <= 1'b0;
    end
    if (ctl.scan && dsq < 19'(NO_MATCH_DIST)) begin
      if (act_r[idx]) begin
        if (!a_ok_r || dsq[17:0] < a_best_r) begin
          a_ok_r <= 1'b1; a_best_r <= dsq[17:0]; a_idx_r <= idx;
        end
      end else begin
        if (!n_ok_r || dsq[17:0] < n_best_r) begin
          n_ok_r <= 1'b1; n_best_r <= dsq[17:0]; n_idx_r <= idx;
        end
      end
    end
    if (ctl.update) begin
      out_r.result_kind <= 1'b0;
      out_r.matched <= use_a;
      out_r.tracker_index <= 6'(u);
      out_r.tracker_active <= use_a ? (nm32 < cfg_r.rate_threshold)
                                    : (nm32 < cfg_r.capture_rate_threshold);
      out_r.pos_x <= nx[15:7];
      out_r.pos_y <= ny[14:7];
      out_r.last <= 1'b1;
    end
    if (ctl.report) begin
      out_r.result_kind <= 1'b1;
      out_r.matched <= 1'b0;
      out_r.tracker_index <= 6'(idx);
      out_r.tracker_active <= act_r[idx];
      out_r.pos_x <= tx_r[idx][15:7];
      out_r.pos_y <= ty_r[idx][14:7];
      out_r.last <= (idx == IDX_W'(TRACKER_COUNT - 1));
    end
  end
endmodule

/* rtl/event_cluster_tracker_core.sv */
// Top level of the event cluster tracker.
// The block handles one item at a time. A change event passes from its input transfer
// through the scan state, one tracker a cycle, and then the update state before its
// verdict is offered; an event that no tracker takes gives no result. End of packet
// passes through the scan state, the cleanup state over every tracker when cleanup
// runs, and the report state before the first report is offered, then one report per
// transfer. The next input is accepted in the cycle after the final result transfer.
module event_cluster_tracker_core (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  ect_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output ect_pkg::out_item_t out_data,
  input  logic               cfg_we,
  input  logic [3:0]         cfg_index,
  input  logic [31:0]        cfg_data
);
  import ect_pkg::*;
  ctl_t ctl;
  sts_t sts;
  logic [IDX_W-1:0] idx;

  ect_ctrl u_ctrl (.clk, .rst_n, .in_valid, .in_ready, .out_ready, .out_valid,
                   .sts, .ctl, .idx);
  ect_datapath u_dp (.clk, .rst_n, .cfg_we, .cfg_index, .cfg_data, .in_data,
                     .ctl, .idx, .sts, .out_data);
endmodule

/* rtl/ect_checker.sv */
// Port-level checker for the event cluster tracker and its bind.
`include "event_cluster_tracker_core_defines.svh"
module ect_checker (
  input logic clk,
  input logic rst_n,
  input logic in_valid,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready
);
  `ECT_ASSERT_IMP(a_no_accept_busy, clk, rst_n, out_valid, !in_ready)
  `ECT_ASSERT_NXT(a_busy_after_in, clk, rst_n, in_valid && in_ready, !in_ready)
  `ECT_ASSERT_NXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid)
endmodule

bind event_cluster_tracker_core ect_checker u_chk (.clk, .rst_n, .in_valid, .in_ready,
  .out_valid, .out_ready);

/* tb/testbench.sv */
// Self-checking testbench for the event cluster tracker core.
`timescale 1ns / 100ps

module testbench;
  import ect_pkg::*;

  localparam int HALF_PERIOD = 10;
  localparam int DRAIN_CYCLES = TRACKER_COUNT + 8;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int HOLD_CYCLES = 300;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_ready;
  in_item_t  in_data = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_item_t out_data;
  logic      cfg_we = 1'b0;
  logic [3:0]  cfg_index = '0;
  logic [31:0] cfg_data = '0;

  event_cluster_tracker_core u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #HALF_PERIOD clk = ~clk;

  in_item_t  pending_items[$];
  out_item_t expected_results[$];
  cfg_t      settings;
  bit [15:0] trk_x[TRACKER_COUNT];
  bit [14:0] trk_y[TRACKER_COUNT];
  bit [31:0] trk_interval[TRACKER_COUNT];
  bit [39:0] trk_last_time[TRACKER_COUNT];
  bit        trk_active[TRACKER_COUNT];
  bit [39:0] last_cleanup;
  int        fail_count = 0;
  int        items_accepted = 0;
  bit        calm = 1'b0;
  bit        activity;
  bit [39:0] clock_now = '0;

  function automatic longint mix_to(longint v, longint t, int k);
    longint d;
    d = t - v;
    if (d >= 0) return v + (d >>> k);
    return v - ((-d + ((longint'(1) << k) - 1)) >>> k);
  endfunction

  function automatic bit [31:0] interval_of(bit [39:0] now, bit [39:0] then_t);
    bit [39:0] d;
    d = now - then_t;
    return (d[39:32] != 0) ? 32'hFFFF_FFFF : d[31:0];
  endfunction

  task automatic push_result(bit kind, bit matched, int idx, bit is_last);
    out_item_t r;
    r.result_kind = kind;
    r.matched = matched;
    r.tracker_index = 6'(idx);
    r.tracker_active = trk_active[idx];
    r.pos_x = trk_x[idx][15:7];
    r.pos_y = trk_y[idx][14:7];
    r.last = is_last;
    expected_results.push_back(r);
  endtask

  task automatic tracker_reset();
    for (int i = 0; i < TRACKER_COUNT; i++) begin
      trk_x[i] = 16'(((2 * i + 1) * 256 / TRACKER_COUNT) % 512) << 7;
      trk_y[i] = 15'(((2 * i + 1) * 128 / TRACKER_COUNT) % 256) << 7;
      trk_interval[i] = 32'd100000;
      trk_last_time[i] = '0;
      trk_active[i] = 1'b0;
    end
    last_cleanup = '0;
    settings = '{18'd225, 18'd900, 32'd1000, 32'd2000, 32'd100000, 32'd1000, 4'd4, 4'd2};
  endtask

  task automatic predict_tracking(in_item_t it);
    int dx, dy, d, a_best, n_best, a_idx, n_idx, k;
    bit a_ok, n_ok;
    bit [31:0] m;
    a_ok = 0; n_ok = 0; a_best = 0; n_best = 0; a_idx = 0; n_idx = 0;
    if (it.kind == 1'b0) begin
      for (int i = 0; i < TRACKER_COUNT; i++) begin
        dx = int'(it.event_x) - int'(trk_x[i][15:7]);
        dy = int'(it.event_y) - int'(trk_y[i][14:7]);
        d = dx * dx + dy * dy;
        if (d >= NO_MATCH_DIST) continue;
        if (trk_active[i]) begin
          if (!a_ok || d < a_best) begin a_ok = 1; a_best = d; a_idx = i; end
        end else begin
          if (!n_ok || d < n_best) begin n_ok = 1; n_best = d; n_idx = i; end
        end
      end
      if (a_ok && a_best < int'(settings.match_dist_sq)) begin
        k = settings.pos_mix_shift;
        trk_x[a_idx] = 16'(mix_to(trk_x[a_idx], longint'(it.event_x) << 7, k));
        trk_y[a_idx] = 15'(mix_to(trk_y[a_idx], longint'(it.event_y) << 7, k));
        trk_interval[a_idx] = 32'(mix_to(trk_interval[a_idx],
          interval_of(it.timestamp, trk_last_time[a_idx]), TIME_MIX_SHIFT));
        trk_last_time[a_idx] = it.timestamp;
        trk_active[a_idx] = trk_interval[a_idx] < settings.rate_threshold;
        push_result(1'b0, 1'b1, a_idx, 1'b1);
      end else if (n_ok && n_best < int'(settings.capture_dist_sq)) begin
        k = settings.capture_mix_shift;
        trk_x[n_idx] = 16'(mix_to(trk_x[n_idx], longint'(it.event_x) << 7, k));
        trk_y[n_idx] = 15'(mix_to(trk_y[n_idx], longint'(it.event_y) << 7, k));
        if (n_best < int'(settings.match_dist_sq))
          trk_interval[n_idx] = 32'(mix_to(trk_interval[n_idx],
            interval_of(it.timestamp, trk_last_time[n_idx]), TIME_MIX_SHIFT));
        trk_last_time[n_idx] = it.timestamp;
        trk_active[n_idx] = trk_interval[n_idx] < settings.capture_rate_threshold;
        push_result(1'b0, 1'b0, n_idx, 1'b1);
      end
    end else begin
      if (40'(it.timestamp - last_cleanup) > {8'd0, settings.cleanup_period}) begin
        for (int i = 0; i < TRACKER_COUNT; i++) begin
          m = 32'(mix_to(trk_interval[i], interval_of(it.timestamp, trk_last_time[i]),
                         settings.pos_mix_shift));
          if (m > settings.interval_max) m = settings.interval_max;
          trk_interval[i] = m;
          if (m > settings.rate_threshold) trk_active[i] = 1'b0;
        end
        last_cleanup = it.timestamp;
      end
      for (int i = 0; i < TRACKER_COUNT; i++)
        push_result(1'b1, 1'b0, i, i == TRACKER_COUNT - 1);
    end
  endtask

  // Driver: offers pending items with random gaps.
  int in_gap = 0;
  always @(posedge clk) begin
    logic     nxt_valid;
    in_item_t nxt_data;
    nxt_valid = in_valid;
    nxt_data = in_data;
    if (!rst_n) begin
      nxt_valid = 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        predict_tracking(in_data);
        items_accepted++;
        nxt_valid = 1'b0;
      end
      if (!nxt_valid) begin
        if (in_gap > 0) begin
          in_gap--;
        end else if (pending_items.size() > 0) begin
          if (!calm && $urandom_range(0, 5) == 0) begin
            in_gap = $urandom_range(1, 5) - 1;
          end else begin
            nxt_valid = 1'b1;
            nxt_data = pending_items.pop_front();
          end
        end
      end
    end
    in_valid <= nxt_valid;
    in_data <= nxt_data;
  end

  // Receiver: random stalls plus one long hold-off once traffic is flowing.
  int  out_gap = 0;
  int  hold_count = 0;
  bit  hold_done = 1'b0;
  always @(posedge clk) begin
    logic nxt_ready;
    nxt_ready = 1'b1;
    if (!rst_n) begin
      nxt_ready = 1'b0;
    end else if (!hold_done && items_accepted >= 200) begin
      hold_done = 1'b1;
      hold_count = HOLD_CYCLES;
      nxt_ready = 1'b0;
    end else if (hold_count > 0) begin
      hold_count--;
      nxt_ready = 1'b0;
    end else if (out_gap > 0) begin
      out_gap--;
      nxt_ready = 1'b0;
    end else if (!calm && $urandom_range(0, 4) == 0) begin
      out_gap = $urandom_range(1, 5) - 1;
      nxt_ready = 1'b0;
    end
    out_ready <= nxt_ready;
  end

  task automatic check_field(string name, int unsigned exp_v, int unsigned act_v);
    if (exp_v != act_v) begin
      $error("%s mismatch: expected %0d, actual %0d", name, exp_v, act_v);
      fail_count++;
    end
  endtask

  // Monitor: compares each result transfer with the oldest prediction.
  always @(posedge clk) begin
    out_item_t e;
    if (rst_n && out_valid && out_ready) begin
      if (expected_results.size() == 0) begin
        $error("unexpected result transfer: %p", out_data);
        fail_count++;
      end else begin
        e = expected_results.pop_front();
        check_field("result_kind", e.result_kind, out_data.result_kind);
        check_field("matched", e.matched, out_data.matched);
        check_field("tracker_index", e.tracker_index, out_data.tracker_index);
        check_field("tracker_active", e.tracker_active, out_data.tracker_active);
        check_field("pos_x", e.pos_x, out_data.pos_x);
        check_field("pos_y", e.pos_y, out_data.pos_y);
        check_field("last", e.last, out_data.last);
      end
    end
  end

  int idle_cycles = 0;
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || cfg_we) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  task automatic push_item(bit kind, int x, int y, bit [39:0] ts);
    in_item_t it;
    it.kind = kind;
    it.event_x = 9'(x);
    it.event_y = 8'(y);
    it.timestamp = ts;
    pending_items.push_back(it);
  endtask

  task automatic wait_idle();
    while (pending_items.size() != 0 || in_valid || expected_results.size() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_settings(cfg_t s);
    logic [31:0] vals[8];
    vals = '{32'(s.match_dist_sq), 32'(s.capture_dist_sq), s.rate_threshold,
             s.capture_rate_threshold, s.interval_max, s.cleanup_period,
             32'(s.pos_mix_shift), 32'(s.capture_mix_shift)};
    for (int i = 0; i < 8; i++) begin
      @(posedge clk);
      cfg_we <= 1'b1;
      cfg_index <= 4'(i);
      cfg_data <= vals[i] | ($urandom() & ~((i < 2) ? 32'h3FFFF : (i > 5) ? 32'hF : '1));
    end
    @(posedge clk);
    cfg_index <= 4'($urandom_range(8, 15));
    cfg_data <= $urandom();
    @(posedge clk);
    cfg_we <= 1'b0;
    settings = s;
  endtask

  task automatic random_traffic(int count);
    int pushed, n, cx, cy, r;
    pushed = 0;
    while (pushed < count) begin
      r = $urandom_range(0, 9);
      if (r < 6) begin
        n = $urandom_range(10, 40);
        r = $urandom_range(0, TRACKER_COUNT - 1);
        cx = trk_x[r][15:7] + $urandom_range(0, 6) - 3;
        cy = trk_y[r][14:7] + $urandom_range(0, 6) - 3;
        for (int j = 0; j < n; j++) begin
          clock_now += $urandom_range(1, 60);
          push_item(1'b0, cx + $urandom_range(0, 8) - 4, cy + $urandom_range(0, 8) - 4,
                    clock_now);
        end
        clock_now += $urandom_range(1, 1500);
        push_item(1'b1, $urandom(), $urandom(), clock_now);
        pushed += n + 1;
      end else if (r < 8) begin
        clock_now += $urandom_range(1, 200);
        push_item(1'b0, $urandom_range(0, 511), $urandom_range(0, 255), clock_now);
        pushed++;
      end else begin
        if ($urandom_range(0, 1)) clock_now = 40'({$urandom(), $urandom()});
        else clock_now += $urandom_range(0, 3000);
        push_item(1'b1, $urandom(), $urandom(), clock_now);
        pushed++;
      end
    end
  endtask

  initial begin
    tracker_reset();
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    push_item(1'b1, 0, 0, 40'd0);
    push_item(1'b0, 32, 16, 40'd5);
    push_item(1'b0, 33, 17, 40'd6);
    push_item(1'b0, 0, 0, 40'd10);
    push_item(1'b0, 511, 255, 40'd20);
    push_item(1'b0, 511, 0, 40'd30);
    push_item(1'b0, 0, 255, 40'd40);
    push_item(1'b0, 64, 32, 40'd50);
    push_item(1'b0, 95, 47, '1);
    push_item(1'b1, 511, 255, 40'hFF_FFFF_FFFF);
    push_item(1'b0, 160, 80, 40'd3);
    push_item(1'b1, 0, 0, 40'd2);
    for (int j = 0; j < 10; j++) push_item(1'b0, 224, 112, 40'd100 + 40'(j));
    push_item(1'b1, 0, 0, 40'd5000);
    wait_idle();

    write_settings('{18'h3FFFF, 18'h3FFFF, '1, '1, '1, '0, 4'd0, 4'd0});
    push_item(1'b0, 64, 32, 40'd7000);
    push_item(1'b1, 0, 0, 40'd7001);
    random_traffic(110);
    wait_idle();

    write_settings('{18'd0, 18'd0, '0, '0, '0, '1, 4'd15, 4'd15});
    random_traffic(40);
    wait_idle();

    write_settings('{18'd225, 18'd900, 32'd1000, 32'd2000, 32'd100000, 32'd1000, 4'd4,
                     4'd2});
    random_traffic(110);
    wait_idle();

    write_settings('{18'($urandom_range(50, 3000)), 18'($urandom_range(200, 5000)),
                     32'($urandom_range(200, 4000)), 32'($urandom_range(500, 8000)),
                     32'($urandom_range(1000, 200000)), 32'($urandom_range(0, 3000)),
                     4'($urandom_range(0, 15)), 4'($urandom_range(0, 15))});
    random_traffic(110);
    wait_idle();

    calm = 1'b1;
    random_traffic(50);
    wait_idle();

    if (fail_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end
endmodule

/* event_cluster_tracker_core.f */
+incdir+rtl
rtl/ect_pkg.sv
rtl/ect_ctrl.sv
rtl/ect_datapath.sv
rtl/event_cluster_tracker_core.sv
rtl/ect_checker.sv
tb/testbench.sv
